/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timer multiplexer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define VTM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define VTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/vtm_pkg.sv */
// ----------------------------------------------------------------------------
// Timer multiplexer package
// Command and result codes and the command record passed front to back.
// ----------------------------------------------------------------------------
package vtm_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [2:0] KIND_FIRED  = 3'd0;
  localparam logic [2:0] KIND_RELOAD = 3'd1;
  localparam logic [2:0] KIND_EXPIRE = 3'd2;
  localparam logic [2:0] KIND_IDLE   = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  localparam logic [7:0] CORRECTION_RESET = 8'd14;

  typedef struct packed {
    op_e         op;
    logic [31:0] id;
    logic [63:0] deadline;
    logic [63:0] now;
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_SCHED = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_SCHED = 4'b1000
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] fired_id;
    logic [31:0] reload;
    logic        last;
  } res_t;

endpackage

/* hdl/vtm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/vtm_front.sv */
// ----------------------------------------------------------------------------
// Timer multiplexer front end
// Accepts commands, decodes the op, forms the saturated deadline, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vtm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [1:0]     op_i,
  input  logic [31:0]    timer_id_i,
  input  logic [31:0]    delay_i,
  input  logic [63:0]    now_i,
  output logic           cmd_valid_o,
  output vtm_pkg::cmd_t  cmd_o,
  input  logic           cmd_pop_i
);

  vtm_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  logic          pop;
  logic [64:0]   sum;
  vtm_pkg::cmd_t new_cmd;

  // Deadline saturates at the top of the 64-bit range.
  assign sum = {1'b0, now_i} + {33'd0, delay_i};

  always_comb begin
    new_cmd.op       = vtm_pkg::op_e'(op_i);
    new_cmd.id       = timer_id_i;
    new_cmd.deadline = sum[64] ? {64{1'b1}} : sum[63:0];
    new_cmd.now      = now_i;
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

/* hdl/vtm_back.sv */
// ----------------------------------------------------------------------------
// Timer multiplexer back end
// Executes commands against the slot table with repeated scan passes and
// produces the fired, table-full and schedule results.
// ----------------------------------------------------------------------------
module vtm_back #(
  parameter int ENTRIES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  vtm_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_data_i,
  output vtm_pkg::res_t  res_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = 32 + 64 + IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  vtm_pkg::state_e state_q, state_d;
  vtm_pkg::mode_e  mode_q, mode_d;
  vtm_pkg::cmd_t   cmd_q, cmd_d;
  vtm_pkg::res_t   res_q, res_d;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]      count_q, count_d;
  logic [7:0]         corr_q;
  logic [IW-1:0]      addr_q, addr_d;
  logic               issue_done_q, issue_done_d;
  logic               rd_v_q, rd_v_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic               pend_v_q, pend_v_d;
  logic [IW-1:0]      pend_r_q, pend_r_d;
  logic               best_v_q, best_v_d;
  logic [IW-1:0]      best_idx_q, best_idx_d;
  logic [63:0]        best_dl_q, best_dl_d;
  logic [IW-1:0]      best_rank_q, best_rank_d;
  logic [31:0]        best_id_q, best_id_d;
  logic [63:0]        diff_q, diff_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;

  logic [31:0]   rd_id;
  logic [63:0]   rd_dl;
  logic [IW-1:0] rd_rank;
  logic [IW-1:0] adj_rank;
  logic          rd_live;
  logic          rank_moves;
  logic          better;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [64:0]   delta;
  logic          due;
  logic [63:0]   pending;

  vtm_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_id   = ram_rdata[WW-1 -: 32];
  assign rd_dl   = ram_rdata[IW +: 64];
  assign rd_rank = ram_rdata[IW-1:0];
  assign rd_live = valid_q[rd_idx_q];

  // A removal during the previous pass is folded into the ranks here.
  assign rank_moves = pend_v_q && (rd_rank > pend_r_q);
  assign adj_rank   = rank_moves ? rd_rank - IW'(1) : rd_rank;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    if (mode_q == vtm_pkg::MODE_STOP) begin
      better = rd_live && (rd_id == cmd_q.id) && !best_v_q;
    end else begin
      better = rd_live && (!best_v_q || (rd_dl < best_dl_q) ||
               ((rd_dl == best_dl_q) && (adj_rank < best_rank_q)));
    end
  end

  assign delta = {1'b0, best_dl_q} - {1'b0, cmd_q.now};
  assign due   = delta[64] || (delta[63:0] == 64'd0);

  always_comb begin
    pending = (diff_q > {56'd0, corr_q}) ? diff_q - {56'd0, corr_q} : diff_q;
  end

  assign cmd_pop_o = (state_q == vtm_pkg::ST_IDLE) && cmd_valid_i;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cmd_d        = cmd_q;
    valid_d      = valid_q;
    count_d      = count_q;
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    rd_v_d       = 1'b0;
    rd_idx_d     = rd_idx_q;
    pend_v_d     = pend_v_q;
    pend_r_d     = pend_r_q;
    best_v_d     = best_v_q;
    best_idx_d   = best_idx_q;
    best_dl_d    = best_dl_q;
    best_rank_d  = best_rank_q;
    best_id_d    = best_id_q;
    diff_d       = diff_q;
    res_d        = res_q;
    res_d.valid  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = rd_idx_q;
    ram_wdata    = {rd_id, rd_dl, adj_rank};

    unique case (state_q)
      vtm_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d        = cmd_i;
          state_d      = vtm_pkg::ST_SCAN;
          addr_d       = '0;
          issue_done_d = 1'b0;
          best_v_d     = 1'b0;
          unique case (cmd_i.op)
            vtm_pkg::OP_START: begin
              mode_d = vtm_pkg::MODE_SCHED;
              if (free_found) begin
                ram_we            = 1'b1;
                ram_waddr         = free_idx;
                ram_wdata         = {cmd_i.id, cmd_i.deadline, count_q[IW-1:0]};
                valid_d[free_idx] = 1'b1;
                count_d           = count_q + CW'(1);
              end else begin
                res_d.valid    = 1'b1;
                res_d.kind     = vtm_pkg::KIND_FULL;
                res_d.fired_id = '0;
                res_d.reload   = '0;
                res_d.last     = 1'b0;
              end
            end
            vtm_pkg::OP_STOP: mode_d = vtm_pkg::MODE_STOP;
            vtm_pkg::OP_TICK: mode_d = vtm_pkg::MODE_TICK;
            default:          mode_d = vtm_pkg::MODE_SCHED;
          endcase
        end
      end

      vtm_pkg::ST_SCAN: begin
        if (!issue_done_q) begin
          rd_v_d   = 1'b1;
          rd_idx_d = addr_q;
          if (addr_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end else begin
            addr_d = addr_q + IW'(1);
          end
        end
        if (rd_v_q) begin
          if (rd_live && rank_moves) begin
            ram_we = 1'b1;
          end
          if (better) begin
            best_v_d    = 1'b1;
            best_idx_d  = rd_idx_q;
            best_dl_d   = rd_dl;
            best_rank_d = adj_rank;
            best_id_d   = rd_id;
          end
          if (rd_idx_q == LAST_IDX) begin
            pend_v_d = 1'b0;
            state_d  = vtm_pkg::ST_EVAL;
          end
        end
      end

      vtm_pkg::ST_EVAL: begin
        if ((mode_q == vtm_pkg::MODE_STOP && best_v_q) ||
            (mode_q == vtm_pkg::MODE_TICK && best_v_q && due)) begin
          valid_d[best_idx_q] = 1'b0;
          count_d             = count_q - CW'(1);
          pend_v_d            = 1'b1;
          pend_r_d            = best_rank_q;
          state_d             = vtm_pkg::ST_SCAN;
          addr_d              = '0;
          issue_done_d        = 1'b0;
          best_v_d            = 1'b0;
          if (mode_q == vtm_pkg::MODE_TICK) begin
            res_d.valid    = 1'b1;
            res_d.kind     = vtm_pkg::KIND_FIRED;
            res_d.fired_id = best_id_q;
            res_d.reload   = '0;
            res_d.last     = 1'b0;
          end
        end else if (mode_q == vtm_pkg::MODE_STOP) begin
          // No more matches: one more pass finds the minimum.
          mode_d       = vtm_pkg::MODE_SCHED;
          state_d      = vtm_pkg::ST_SCAN;
          addr_d       = '0;
          issue_done_d = 1'b0;
          best_v_d     = 1'b0;
        end else if (!best_v_q) begin
          res_d.valid    = 1'b1;
          res_d.kind     = vtm_pkg::KIND_IDLE;
          res_d.fired_id = '0;
          res_d.reload   = '0;
          res_d.last     = 1'b1;
          state_d        = vtm_pkg::ST_IDLE;
        end else if (due) begin
          res_d.valid    = 1'b1;
          res_d.kind     = vtm_pkg::KIND_EXPIRE;
          res_d.fired_id = '0;
          res_d.reload   = '0;
          res_d.last     = 1'b1;
          state_d        = vtm_pkg::ST_IDLE;
        end else begin
          diff_d  = delta[63:0];
          state_d = vtm_pkg::ST_SCHED;
        end
      end

      vtm_pkg::ST_SCHED: begin
        res_d.valid    = 1'b1;
        res_d.kind     = vtm_pkg::KIND_RELOAD;
        res_d.fired_id = '0;
        res_d.reload   = (pending[63:32] != 32'd0) ? 32'hFFFF_FFFF : pending[31:0];
        res_d.last     = 1'b1;
        state_d        = vtm_pkg::ST_IDLE;
      end

      default: state_d = vtm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= vtm_pkg::ST_IDLE;
      mode_q       <= vtm_pkg::MODE_SCHED;
      valid_q      <= '0;
      count_q      <= '0;
      corr_q       <= vtm_pkg::CORRECTION_RESET;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_v_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      best_v_q     <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      if (cfg_we_i) begin
        corr_q <= cfg_data_i;
      end
      addr_q       <= addr_d;
      issue_done_q <= issue_done_d;
      rd_v_q       <= rd_v_d;
      pend_v_q     <= pend_v_d;
      best_v_q     <= best_v_d;
      res_q        <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q          <= cmd_d;
    rd_idx_q       <= rd_idx_d;
    pend_r_q       <= pend_r_d;
    best_idx_q     <= best_idx_d;
    best_dl_q      <= best_dl_d;
    best_rank_q    <= best_rank_d;
    best_id_q      <= best_id_d;
    diff_q         <= diff_d;
  end

  assign res_o = res_q;

endmodule

/* hdl/virtual_timer_multiplexer.sv */
// ----------------------------------------------------------------------------
// Virtual timer multiplexer
// Many virtual timers share one hardware countdown through a deadline table.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; a two-entry
// queue sits in front of the executing logic, so up to two commands can be
// taken while an earlier one is still being worked. Every command ends with
// exactly one schedule result (idle, expire now or reload) marked by last_o.
// A tick first reports each expired timer as a fired result, earliest
// deadline first and oldest start first among equal deadlines; a start into a
// full table first reports table full. Results appear on the result ports for
// one cycle with result_valid_o and cannot be held off, so the receiver must
// take every one. Deadlines live in a single-port-read slot RAM, and all work
// is done in passes that read one slot per cycle, each followed by an
// evaluation step. A start or an unused op takes one pass; a stop that
// removes k timers takes k + 2 passes; a tick that fires k timers takes
// k + 1 passes. A reload result then passes through the schedule state.
// The correction register may be written at any time the block is idle
// and is always ready.
module virtual_timer_multiplexer #(
  parameter int ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] timer_id_i,
  input  logic [31:0] delay_i,
  input  logic [63:0] now_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_correction_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [31:0] fired_id_o,
  output logic [31:0] reload_o,
  output logic        last_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  vtm_pkg::cmd_t cmd;
  vtm_pkg::res_t res;

  // The correction register accepts a transfer in every cycle.
  assign cfg_ready_o = 1'b1;

  vtm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .timer_id_i  (timer_id_i),
    .delay_i     (delay_i),
    .now_i       (now_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  vtm_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_correction_i),
    .res_o       (res)
  );

  assign result_valid_o = res.valid;
  assign kind_o         = res.kind;
  assign fired_id_o     = res.fired_id;
  assign reload_o       = res.reload;
  assign last_o         = res.last;

endmodule

/* hdl/vtm_checker.sv */
// ----------------------------------------------------------------------------
// Timer multiplexer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [2:0]  kind_o,
  input logic [31:0] fired_id_o,
  input logic [31:0] reload_o,
  input logic        last_o
);

  `VTM_ASSERT(a_fired_not_last, clk_i, rst_ni, result_valid_o && kind_o == vtm_pkg::KIND_FIRED |-> !last_o && reload_o == 32'd0, "fired result marked last")
  `VTM_ASSERT(a_full_not_last, clk_i, rst_ni, result_valid_o && kind_o == vtm_pkg::KIND_FULL |-> !last_o && fired_id_o == 32'd0, "table full result malformed")
  `VTM_ASSERT(a_sched_last, clk_i, rst_ni, result_valid_o && (kind_o == vtm_pkg::KIND_RELOAD || kind_o == vtm_pkg::KIND_EXPIRE || kind_o == vtm_pkg::KIND_IDLE) |-> last_o && fired_id_o == 32'd0, "schedule result not last")
  `VTM_ASSERT(a_kind_legal, clk_i, rst_ni, result_valid_o |-> kind_o <= vtm_pkg::KIND_FULL, "result kind out of range")

endmodule

bind virtual_timer_multiplexer vtm_checker u_vtm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .fired_id_o     (fired_id_o),
  .reload_o       (reload_o),
  .last_o         (last_o)
);

/* tb/virtual_timer_multiplexer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Virtual timer multiplexer testbench
// Drives start, stop, tick and unused-op commands with bursty gaps, predicts every
// fired, table-full and schedule result from a behavioral deadline table,
// and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module virtual_timer_multiplexer_tb;

  localparam int ENTRIES = 32;
  // A long stop can take ENTRIES + 2 passes.
  localparam int DRAIN_CYCLES = 1500;

  // One predicted result.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fired_id;
    logic [31:0] reload;
    logic        last;
  } timer_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  op_i;
  logic [31:0] timer_id_i;
  logic [31:0] delay_i;
  logic [63:0] now_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_correction_i;
  logic        result_valid_o;
  logic [2:0]  kind_o;
  logic [31:0] fired_id_o;
  logic [31:0] reload_o;
  logic        last_o;

  // Behavioral copy of the deadline table and the correction register.
  logic        slot_live[ENTRIES];
  logic [31:0] slot_timer[ENTRIES];
  logic [63:0] slot_due[ENTRIES];
  int unsigned slot_rank[ENTRIES];
  int unsigned live_count;
  logic [7:0]  correction;

  timer_result_t pending_results[$];
  int unsigned   mismatch_count;
  logic [63:0]   clock_now;

  virtual_timer_multiplexer #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .timer_id_i      (timer_id_i),
    .delay_i         (delay_i),
    .now_i           (now_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_correction_i(cfg_correction_i),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .fired_id_o      (fired_id_o),
    .reload_o        (reload_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Removes one slot and closes the gap it leaves in the insertion ranks.
  function automatic void drop_timer(int idx);
    slot_live[idx] = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (slot_live[j] && slot_rank[j] > slot_rank[idx]) slot_rank[j]--;
    end
    if (live_count > 0) live_count--;
  endfunction

  // Live slot with the earliest deadline not after the limit; ties go to the
  // oldest start. Returns -1 if no slot qualifies.
  function automatic int earliest_due(logic [63:0] limit);
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_due[i] <= limit) begin
        if (best < 0 || slot_due[i] < slot_due[best] ||
            (slot_due[i] == slot_due[best] && slot_rank[i] < slot_rank[best])) begin
          best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic void push_result(logic [2:0] kind, logic [31:0] id, logic [31:0] rl,
                                      logic is_last);
    timer_result_t r;
    r.kind = kind;
    r.fired_id = id;
    r.reload = rl;
    r.last = is_last;
    pending_results.push_back(r);
  endfunction

  // Updates the table for one command and queues every result it causes.
  function automatic void predict_timer_results(vtm_pkg::op_e op, logic [31:0] id,
                                                logic [31:0] dly, logic [63:0] now);
    int          free_slot;
    int          k;
    logic [64:0] sum;
    logic [63:0] gap;
    free_slot = -1;
    case (op)
      vtm_pkg::OP_START: begin
        for (int i = ENTRIES - 1; i >= 0; i--) if (!slot_live[i]) free_slot = i;
        if (free_slot < 0) begin
          push_result(vtm_pkg::KIND_FULL, '0, '0, 1'b0);
        end else begin
          sum = {1'b0, now} + {33'd0, dly};
          slot_live[free_slot]  = 1'b1;
          slot_timer[free_slot] = id;
          slot_due[free_slot]   = sum[64] ? '1 : sum[63:0];
          slot_rank[free_slot]  = live_count;
          live_count++;
        end
      end
      vtm_pkg::OP_STOP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i] && slot_timer[i] == id) drop_timer(i);
        end
      end
      vtm_pkg::OP_TICK: begin
        k = earliest_due(now);
        while (k >= 0) begin
          push_result(vtm_pkg::KIND_FIRED, slot_timer[k], '0, 1'b0);
          drop_timer(k);
          k = earliest_due(now);
        end
      end
      default: ;
    endcase
    // Closing schedule result.
    k = earliest_due('1);
    if (k < 0) begin
      push_result(vtm_pkg::KIND_IDLE, '0, '0, 1'b1);
    end else if (slot_due[k] <= now) begin
      push_result(vtm_pkg::KIND_EXPIRE, '0, '0, 1'b1);
    end else begin
      gap = slot_due[k] - now;
      if (gap > {56'd0, correction}) gap = gap - {56'd0, correction};
      push_result(vtm_pkg::KIND_RELOAD, '0, (gap > 64'hFFFF_FFFF) ? '1 : gap[31:0], 1'b1);
    end
  endfunction

  // Sends one command; the prediction is made at the accepting edge.
  task automatic send_command(vtm_pkg::op_e op, logic [31:0] id, logic [31:0] dly,
                              logic [63:0] now);
    start_i    = 1'b1;
    op_i       = op;
    timer_id_i = id;
    delay_i    = dly;
    now_i      = now;
    do @(posedge clk_i); while (busy_o);
    predict_timer_results(op, id, dly, now);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // Bursty sender: after a random burst, idle for a random gap.
  int unsigned burst_left;
  task automatic sender_pause();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
    burst_left--;
  endtask

  // Waits until every result is in, plus the block's worst latency for safety.
  task automatic wait_quiet();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_correction(logic [7:0] value);
    cfg_valid_i      <= 1'b1;
    cfg_correction_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    correction = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Extremes of the fields, every op and the named special cases.
  task automatic test_directed();
    send_command(vtm_pkg::OP_TICK, '0, '0, '0);                        // empty table: idle
    send_command(vtm_pkg::OP_START, 32'hFFFF_FFFF, '1, 64'd100);       // long reload
    send_command(vtm_pkg::OP_START, 32'h5, 32'd3, 64'd100);
    send_command(vtm_pkg::OP_START, 32'h5, 32'd3, 64'd100);            // duplicate id
    send_command(vtm_pkg::OP_START, 32'h7, 32'd0, '1);                 // deadline at top
    send_command(vtm_pkg::OP_START, 32'h8, '1, 64'hFFFF_FFFF_FFFF_FFF0); // overflow saturates
    send_command(vtm_pkg::OP_STOP, 32'h1234, '0, 64'd101);             // stop without match
    send_command(vtm_pkg::OP_NONE, '1, '1, 64'd101);                   // unused op
    send_command(vtm_pkg::OP_TICK, '0, '0, 64'd103);                   // fires both id 5
    send_command(vtm_pkg::OP_STOP, 32'h5, '0, 64'd104);                // nothing left with id 5
    send_command(vtm_pkg::OP_START, 32'h9, 32'd10, 64'd104);           // pending under correction
    send_command(vtm_pkg::OP_TICK, '0, '0, 64'd200);                   // fires id 9, then reload
    send_command(vtm_pkg::OP_TICK, '0, '0, '1);                        // fires everything
    // Fill the table, then overflow it.
    for (int i = 0; i <= ENTRIES; i++) begin
      send_command(vtm_pkg::OP_START, 32'(i), 32'd50, 64'd1000);
    end
    send_command(vtm_pkg::OP_STOP, 32'd3, '0, 64'd1000);
    send_command(vtm_pkg::OP_TICK, '0, '0, 64'd1050);                  // mass fire in rank order
  endtask

  // Mostly sensible sequences around a rising clock, with some noise.
  task automatic test_random(int count);
    vtm_pkg::op_e op;
    logic [31:0]  id;
    logic [31:0]  dly;
    logic [63:0]  now;
    for (int n = 0; n < count; n++) begin
      sender_pause();
      clock_now = clock_now + $urandom_range(0, 40);
      now = clock_now;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = vtm_pkg::OP_START;
        4, 5:       op = vtm_pkg::OP_STOP;
        6, 7, 8:    op = vtm_pkg::OP_TICK;
        default:    op = vtm_pkg::OP_NONE;
      endcase
      id  = $urandom_range(0, 15);
      dly = $urandom_range(0, 300);
      case ($urandom_range(0, 15))
        0: id  = $urandom();
        1: dly = $urandom();
        2: now = {$urandom(), $urandom()};                       // time jump noise
        default: ;
      endcase
      send_command(op, id, dly, now);
      if (n == count / 2) while (pending_results.size() != 0) @(negedge clk_i);
    end
  endtask

  // Result checker: every strobe takes the oldest expectation.
  always @(posedge clk_i) begin
    timer_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result: kind %0d id %h reload %h last %b",
                                           kind_o, fired_id_o, reload_o, last_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (kind_o !== exp_r.kind || fired_id_o !== exp_r.fired_id ||
            reload_o !== exp_r.reload || last_o !== exp_r.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected kind %0d id %h reload %h last %b", exp_r.kind,
                     exp_r.fired_id, exp_r.reload, exp_r.last);
            $display("          actual   kind %0d id %h reload %h last %b", kind_o,
                     fired_id_o, reload_o, last_o);
          end
        end
      end
    end
  end

  // Generous upper bound on the run.
  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    op_i             = vtm_pkg::OP_TICK;
    timer_id_i       = '0;
    delay_i          = '0;
    now_i            = '0;
    cfg_valid_i      = 1'b0;
    cfg_correction_i = '0;
    mismatch_count   = 0;
    burst_left       = 0;
    clock_now        = 64'd5000;
    live_count       = 0;
    correction       = vtm_pkg::CORRECTION_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_rank[i] = 0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    wait_quiet();
    write_correction(8'd0);
    test_random(40);
    wait_quiet();
    write_correction(8'd255);
    send_command(vtm_pkg::OP_START, 32'hA, 32'd100, clock_now);  // pending under correction
    test_random(40);
    wait_quiet();
    write_correction(8'($urandom()));
    test_random(40);
    wait_quiet();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
